// ----- hw/rtl/fsfd_pkg.sv -----
// fsfd_pkg: shared types and constants for the force sensor frame decoder
// holds header bytes, frame position codes, axis codes and gain reset values
// no dependencies
`default_nettype none

package fsfd_pkg;

  // header bytes that open every frame
  localparam logic [7:0] HDR_B0 = 8'hAA;
  localparam logic [7:0] HDR_B1 = 8'h07;
  localparam logic [7:0] HDR_B2 = 8'h08;
  localparam logic [7:0] HDR_B3 = 8'h0A;

  // frame position codes
  localparam logic [3:0] POS_HUNT   = 4'd0;
  localparam logic [3:0] POS_SKIP   = 4'd4;
  localparam logic [3:0] POS_DATA   = 4'd8;
  localparam logic [3:0] POS_X_LO   = 4'd9;
  localparam logic [3:0] POS_Y_LO   = 4'd11;
  localparam logic [3:0] POS_LAST   = 4'd13;
  localparam logic [3:0] POS_ONE    = 4'd1;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // register indexes
  localparam logic [1:0] REG_GAIN_X = 2'd0;
  localparam logic [1:0] REG_GAIN_Y = 2'd1;
  localparam logic [1:0] REG_GAIN_Z = 2'd2;

  // gain reset values, unsigned Q0.24 newtons per count
  localparam logic [23:0] GAIN_X_RST = 24'd125515;
  localparam logic [23:0] GAIN_Y_RST = 24'd123151;
  localparam logic [23:0] GAIN_Z_RST = 24'd474142;

  // rounding bias before dropping eight fraction bits
  localparam logic signed [40:0] ROUND_BIAS = 41'sd128;

  // saturation limits of the tared forces
  localparam logic signed [31:0] FORCE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FORCE_MIN = 32'sh8000_0000;

  // one completed axis count out of the parser
  typedef struct packed {
    logic               vld;
    logic [1:0]         axis;
    logic signed [15:0] count;
  } sample_t;

  // expected header byte at a header position
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      2'd2:    b = HDR_B2;
      default: b = HDR_B3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fsfd_parse.sv -----
// fsfd_parse: header hunt and frame position tracking of the byte stream
// emits one signed axis count on each axis low byte
// depends on fsfd_pkg
`default_nettype none

module fsfd_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_take,
  input  wire logic [7:0]       rx_byte,
  output fsfd_pkg::sample_t     sample
);

  logic [3:0] pos_r;
  logic [3:0] pos_nxt;
  logic [7:0] hold_r;
  logic [7:0] hold_nxt;

  // next frame position and sample decode for the byte on the input
  always_comb begin
    pos_nxt      = pos_r;
    hold_nxt     = hold_r;
    sample.vld   = 1'b0;
    sample.axis  = fsfd_pkg::AXIS_Z;
    sample.count = $signed({hold_r, rx_byte});
    priority if (pos_r < fsfd_pkg::POS_SKIP) begin
      if (rx_byte == fsfd_pkg::hdr_byte(pos_r[1:0])) begin
        pos_nxt = pos_r + 4'd1;
      end else if (rx_byte == fsfd_pkg::HDR_B0) begin
        pos_nxt = fsfd_pkg::POS_ONE;
      end else begin
        pos_nxt = fsfd_pkg::POS_HUNT;
      end
    end else if (pos_r < fsfd_pkg::POS_DATA) begin
      pos_nxt = pos_r + 4'd1;
    end else if (pos_r > fsfd_pkg::POS_LAST) begin
      pos_nxt = fsfd_pkg::POS_HUNT;
    end else if (!pos_r[0]) begin
      // high byte of an axis
      hold_nxt = rx_byte;
      pos_nxt  = pos_r + 4'd1;
    end else begin
      // low byte completes an axis
      sample.vld = byte_take;
      if (pos_r == fsfd_pkg::POS_X_LO) begin
        sample.axis = fsfd_pkg::AXIS_X;
        pos_nxt     = pos_r + 4'd1;
      end else if (pos_r == fsfd_pkg::POS_Y_LO) begin
        sample.axis = fsfd_pkg::AXIS_Y;
        pos_nxt     = pos_r + 4'd1;
      end else begin
        sample.axis = fsfd_pkg::AXIS_Z;
        pos_nxt     = fsfd_pkg::POS_HUNT;
      end
    end
  end

  // position and high byte advance on each taken byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= fsfd_pkg::POS_HUNT;
      hold_r <= 8'd0;
    end else if (byte_take) begin
      pos_r  <= pos_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/force_sensor_frame_decoder_top.sv -----
// force_sensor_frame_decoder_top: frame decoder, gain scaling and tare stage
// instantiates fsfd_parse, uses fsfd_pkg
`default_nettype none

// Takes one sensor byte per clock while in_stall is low. Frames start with AA 07 08 0A, four
// bytes are skipped, then X, Y and Z arrive as big-endian signed 16-bit
// counts. Each count is scaled by its 24-bit gain and rounded to Q15.16
// newtons through a three-register pipe (operands, product, rounded value),
// and each frame's result is loaded into the output register as its Z value
// leaves the pipe. The first frame after reset becomes the tare offset and
// is reported as zeros with out_tare_frame set; later frames report the
// saturated difference. Input is stalled only when every pipe register is
// full behind a stalled output. Gains are written through the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
module force_sensor_frame_decoder_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [7:0]         in_rx_byte,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [31:0] out_force_x,
  output      logic signed [31:0] out_force_y,
  output      logic signed [31:0] out_force_z,
  output      logic               out_tare_frame,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  // configuration registers
  logic [23:0] gain_x_r;
  logic [23:0] gain_y_r;
  logic [23:0] gain_z_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_r <= fsfd_pkg::GAIN_X_RST;
      gain_y_r <= fsfd_pkg::GAIN_Y_RST;
      gain_z_r <= fsfd_pkg::GAIN_Z_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == fsfd_pkg::REG_GAIN_X) gain_x_r <= pwdata[23:0];
      if (cfg_idx == fsfd_pkg::REG_GAIN_Y) gain_y_r <= pwdata[23:0];
      if (cfg_idx == fsfd_pkg::REG_GAIN_Z) gain_z_r <= pwdata[23:0];
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      fsfd_pkg::REG_GAIN_X: prdata = {8'd0, gain_x_r};
      fsfd_pkg::REG_GAIN_Y: prdata = {8'd0, gain_y_r};
      fsfd_pkg::REG_GAIN_Z: prdata = {8'd0, gain_z_r};
      default:              prdata = 32'd0;
    endcase
  end

  // pipe control
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic [1:0] s1_axis_r, s2_axis_r, s3_axis_r;
  logic out_free, adv3, s3_ready, adv2, s2_ready, adv1, s1_ready;
  logic in_take;

  assign out_free = !out_vld_r || !out_stall;
  assign adv3     = s3_vld_r && ((s3_axis_r != fsfd_pkg::AXIS_Z) || out_free);
  assign s3_ready = !s3_vld_r || adv3;
  assign adv2     = s2_vld_r && s3_ready;
  assign s2_ready = !s2_vld_r || adv2;
  assign adv1     = s1_vld_r && s2_ready;
  assign s1_ready = !s1_vld_r || adv1;
  assign in_stall = !s1_ready;
  assign in_take  = in_valid && s1_ready;

  // byte parser
  fsfd_pkg::sample_t sample;

  fsfd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (in_take),
    .rx_byte   (in_rx_byte),
    .sample    (sample)
  );

  // stage 1: count and gain of a completed axis
  logic signed [15:0] s1_count_r;
  logic [23:0]        s1_gain_r;
  logic [23:0]        gain_sel;

  always_comb begin
    unique case (sample.axis)
      fsfd_pkg::AXIS_X: gain_sel = gain_x_r;
      fsfd_pkg::AXIS_Y: gain_sel = gain_y_r;
      default:          gain_sel = gain_z_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= sample.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && sample.vld) begin
      s1_axis_r  <= sample.axis;
      s1_count_r <= sample.count;
      s1_gain_r  <= gain_sel;
    end
  end

  // stage 2: exact product, signed 41 bits
  logic signed [40:0] prod;
  logic signed [40:0] s2_prod_r;

  assign prod = 41'(s1_count_r) * 41'($signed({1'b0, s1_gain_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_axis_r <= s1_axis_r;
      s2_prod_r <= prod;
    end
  end

  // stage 3: round to Q15.16, ties toward plus infinity
  logic signed [40:0] rnd_sum;
  logic signed [31:0] s3_q_r;

  assign rnd_sum = s2_prod_r + fsfd_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_ready) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_axis_r <= s2_axis_r;
      s3_q_r    <= rnd_sum[39:8];
    end
  end

  // frame values and tare offsets
  logic signed [31:0] axis_x_r, axis_y_r;
  logic signed [31:0] tare_x_r, tare_y_r, tare_z_r;
  logic               tare_done_r;
  logic               z_load;

  assign z_load = adv3 && (s3_axis_r == fsfd_pkg::AXIS_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r    <= 32'sd0;
      axis_y_r    <= 32'sd0;
      tare_x_r    <= 32'sd0;
      tare_y_r    <= 32'sd0;
      tare_z_r    <= 32'sd0;
      tare_done_r <= 1'b0;
    end else begin
      if (adv3 && (s3_axis_r == fsfd_pkg::AXIS_X)) axis_x_r <= s3_q_r;
      if (adv3 && (s3_axis_r == fsfd_pkg::AXIS_Y)) axis_y_r <= s3_q_r;
      if (z_load && !tare_done_r) begin
        tare_x_r    <= axis_x_r;
        tare_y_r    <= axis_y_r;
        tare_z_r    <= s3_q_r;
        tare_done_r <= 1'b1;
      end
    end
  end

  // saturating tare subtraction
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      r = d[32] ? fsfd_pkg::FORCE_MIN : fsfd_pkg::FORCE_MAX;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

  // output register
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_tare_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (z_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (z_load) begin
      if (!tare_done_r) begin
        out_x_r    <= 32'sd0;
        out_y_r    <= 32'sd0;
        out_z_r    <= 32'sd0;
        out_tare_r <= 1'b1;
      end else begin
        out_x_r    <= sat_sub(axis_x_r, tare_x_r);
        out_y_r    <= sat_sub(axis_y_r, tare_y_r);
        out_z_r    <= sat_sub(s3_q_r, tare_z_r);
        out_tare_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_force_x    = out_x_r;
  assign out_force_y    = out_y_r;
  assign out_force_z    = out_z_r;
  assign out_tare_frame = out_tare_r;

endmodule

`default_nettype wire
